### rtl/fixed_point_arith_unit_assert.svh
// Assertion macros for the fixed-point arithmetic unit checker
`ifndef FIXED_POINT_ARITH_UNIT_ASSERT_SVH
`define FIXED_POINT_ARITH_UNIT_ASSERT_SVH

// same-cycle implication, idle during reset
`define FPAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpau check failed");

// next-cycle implication, idle during reset
`define FPAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpau check failed");

`endif

### rtl/fpau_pkg.sv
package fpau_pkg;

  localparam int unsigned FRAC_BITS = 16;

  // iterative section: 64 divide steps, 29 root steps
  localparam int unsigned NUM_STG     = 16;
  localparam int unsigned DIV_STEPS   = 64;
  localparam int unsigned DIV_PER_STG = DIV_STEPS / NUM_STG;
  localparam int unsigned SQ_STEPS    = 29;
  localparam int unsigned SQ_PER_STG  = (SQ_STEPS + NUM_STG - 1) / NUM_STG;
  localparam logic signed [63:0] SQRT_TOP_BIT = 64'sh0100_0000_0000_0000;

  localparam logic [2:0] MODE_MUL    = 3'd0;
  localparam logic [2:0] MODE_DIV    = 3'd1;
  localparam logic [2:0] MODE_FSQRT  = 3'd2;
  localparam logic [2:0] MODE_MULDIV = 3'd3;
  localparam logic [2:0] MODE_SCALE  = 3'd4;
  localparam logic [2:0] MODE_ISQRT  = 3'd5;

  localparam logic [1:0] KIND_PASS = 2'd0;
  localparam logic [1:0] KIND_DIV  = 2'd1;
  localparam logic [1:0] KIND_SQRT = 2'd2;

  // x: dividend/quotient or radicand; y: root or pass-through result
  typedef struct packed {
    logic               valid;
    logic [1:0]         kind;
    logic               neg;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [31:0]        rem;
    logic [31:0]        dv;
  } stage_t;

  function automatic stage_t iter_step(stage_t s_in, int unsigned idx);
    stage_t             s;
    logic [32:0]        tr;
    logic signed [63:0] t;
    logic signed [63:0] bb;
    int unsigned        n;
    s = s_in;
    unique case (s.kind)
      KIND_DIV: begin
        for (int unsigned k = 0; k < DIV_PER_STG; k++) begin
          tr = {s.rem, s.x[63]};
          s.x = {s.x[62:0], 1'b0};
          if (tr >= {1'b0, s.dv}) begin
            tr = tr - {1'b0, s.dv};
            s.x[0] = 1'b1;
          end
          s.rem = tr[31:0];
        end
      end
      KIND_SQRT: begin
        for (int unsigned k = 0; k < SQ_PER_STG; k++) begin
          n = idx * SQ_PER_STG + k;
          if (n < SQ_STEPS) begin
            bb = SQRT_TOP_BIT >>> (2 * n);
            t = s.y + bb;
            s.y = s.y >>> 1;
            if (t <= s.x) begin
              s.x = s.x - t;
              s.y = s.y + bb;
            end
          end
        end
      end
      default: s = s_in;
    endcase
    return s;
  endfunction

endpackage

### rtl/fixed_point_arith_unit.sv
// Fixed-point arithmetic unit, Q-format with 16 fraction bits.
// Stages: capture, decode, 16-stage divide/root pipe, sign fix and select.
// Throughput: one item per cycle unless the output stalls.
// Output stall freezes the whole pipe; a bubble at the output is absorbed.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module fixed_point_arith_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_mode,
  input  logic signed [31:0]  in_operand_a,
  input  logic signed [31:0]  in_operand_b,
  input  logic signed [31:0]  in_divisor,
  input  logic [5:0]          in_shift_amount,
  input  logic signed [63:0]  in_wide_operand,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_result
);
  import fpau_pkg::*;

  // pipe advances unless a finished item sits unclaimed at the output
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // ---- stage 1: operand capture and 32x32 signed product ----
  logic               p_valid_r;
  logic [2:0]         p_mode_r;
  logic signed [31:0] p_a_r, p_b_r, p_d_r;
  logic [5:0]         p_sh_r;
  logic signed [63:0] p_w_r, p_prod_r;
  logic signed [63:0] prod_nxt;

  assign prod_nxt = in_operand_a * in_operand_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_mode_r <= in_mode;
      p_a_r    <= in_operand_a;
      p_b_r    <= in_operand_b;
      p_d_r    <= in_divisor;
      p_sh_r   <= in_shift_amount;
      p_w_r    <= in_wide_operand;
      p_prod_r <= prod_nxt;
    end
  end

  // ---- stage 2: mode decode, shifts, magnitudes and signs ----
  stage_t             set_nxt;
  logic signed [63:0] a_scaled;
  logic signed [63:0] num;
  logic signed [31:0] den;

  assign a_scaled = 64'(p_a_r) <<< FRAC_BITS;

  always_comb begin
    set_nxt       = '0;
    set_nxt.valid = p_valid_r;
    num           = a_scaled;
    den           = p_b_r;
    unique case (p_mode_r) inside
      MODE_MUL:   set_nxt.y = p_prod_r >>> FRAC_BITS;
      MODE_SCALE: set_nxt.y = p_prod_r >>> p_sh_r;
      MODE_DIV, MODE_MULDIV: begin
        if (p_mode_r == MODE_MULDIV) begin
          num = p_prod_r;
          den = p_d_r;
        end
        if (den == 32'sd0) begin
          // zero divisor hands back operand a
          set_nxt.y = 64'(p_a_r);
        end else begin
          set_nxt.kind = KIND_DIV;
          set_nxt.neg  = num[63] ^ den[31];
          set_nxt.x    = num[63] ? -num : num;
          set_nxt.dv   = den[31] ? 32'(-den) : den;
        end
      end
      MODE_FSQRT: begin
        set_nxt.kind = KIND_SQRT;
        set_nxt.x    = a_scaled;
      end
      MODE_ISQRT: begin
        set_nxt.kind = KIND_SQRT;
        set_nxt.x    = p_w_r;
      end
      default: set_nxt.y = '0;
    endcase
  end

  // ---- stages 3..18: shared divide / root iteration pipe ----
  stage_t st_r [0:NUM_STG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0].valid <= 1'b0;
    end else if (adv) begin
      st_r[0] <= set_nxt;
    end
  end

  for (genvar g = 0; g < NUM_STG; g++) begin : g_iter
    stage_t nxt;
    always_comb nxt = iter_step(st_r[g], g);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[g+1].valid <= 1'b0;
      end else if (adv) begin
        st_r[g+1] <= nxt;
      end
    end
  end

  // ---- stage 19: sign fix and result select ----
  logic [31:0] q_lo;
  logic [31:0] res_nxt;

  assign q_lo = st_r[NUM_STG].x[31:0];

  always_comb begin
    unique case (st_r[NUM_STG].kind)
      KIND_DIV: res_nxt = st_r[NUM_STG].neg ? -q_lo : q_lo;
      default:  res_nxt = st_r[NUM_STG].y[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= st_r[NUM_STG].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result <= res_nxt;
    end
  end

endmodule

### rtl/fpau_checker.sv
module fpau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_result
);
`include "fixed_point_arith_unit_assert.svh"

  // input back-pressure only ever comes from a held result
  `FPAU_ASSERT_IMP(a_stall_src, clk, rst_n, in_stall, out_valid && out_stall)
  // an empty output slot never blocks the input
  `FPAU_ASSERT_IMP(a_bubble, clk, rst_n, !out_valid, !in_stall)
  // a held result stays put
  `FPAU_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_result))

endmodule

bind fixed_point_arith_unit fpau_checker u_fpau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_result (out_result)
);

### tb/fixed_point_arith_unit_checker.sv
`timescale 1ns / 100ps

module fixed_point_arith_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  input  logic signed [31:0] in_divisor,
  input  logic [5:0]         in_shift_amount,
  input  logic signed [63:0] in_wide_operand,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_result,
  output int                 fail_count,
  output int                 pending_count
);
  import fpau_pkg::*;

  logic [31:0] result_q[$];

  // bit-pair root, 29 steps from the top trial bit
  function automatic logic signed [63:0] pair_root(logic signed [63:0] rad);
    logic signed [63:0] root;
    logic signed [63:0] trial;
    logic signed [63:0] bit_w;
    root  = '0;
    bit_w = SQRT_TOP_BIT;
    while (bit_w != 0) begin
      trial = root + bit_w;
      root  = root >>> 1;
      if (trial <= rad) begin
        rad  = rad - trial;
        root = root + bit_w;
      end
      bit_w = bit_w >>> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] arith_result(
    logic [2:0] mode, logic signed [31:0] a, logic signed [31:0] b,
    logic signed [31:0] d, logic [5:0] sh, logic signed [63:0] w);
    logic signed [63:0] a64;
    logic signed [63:0] b64;
    logic signed [63:0] d64;
    logic signed [63:0] prod;
    logic signed [63:0] val;
    a64  = a;
    b64  = b;
    d64  = d;
    prod = a64 * b64;
    case (mode)
      MODE_MUL:    val = prod >>> FRAC_BITS;
      MODE_DIV:    val = (b == 0) ? a64 : (a64 <<< FRAC_BITS) / b64;
      MODE_FSQRT:  val = pair_root(a64 <<< FRAC_BITS);
      MODE_MULDIV: val = (d == 0) ? a64 : prod / d64;
      MODE_SCALE:  val = prod >>> sh;
      MODE_ISQRT:  val = pair_root(w);
      default:     val = '0;
    endcase
    return val[31:0];
  endfunction

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      result_q.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        result_q.push_back(arith_result(in_mode, in_operand_a, in_operand_b,
                                        in_divisor, in_shift_amount, in_wide_operand));
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_result);
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (want !== out_result) begin
            $display("%0t: result expected %h actual %h", $time, want, out_result);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= result_q.size();
    end
  end

endmodule

### tb/fixed_point_arith_unit_tb.sv
`timescale 1ns / 100ps

module fixed_point_arith_unit_tb;
  import fpau_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_mode = MODE_MUL;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic signed [31:0] in_divisor = '0;
  logic [5:0]         in_shift_amount = '0;
  logic signed [63:0] in_wide_operand = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result;
  int                 fail_count;
  int                 pending_count;
  bit                 hold_off = 1'b0;  // long receiver hold-off request
  bit                 hold_done = 1'b0;

  always #2 clk = ~clk;

  fixed_point_arith_unit u_top (.*);

  fixed_point_arith_unit_checker u_chk (.*);

  // Receiver: own stall pattern, phases of no stalls, light and heavy stalls,
  // and one long hold-off so the pipe fills and backs up to the input.
  initial begin
    int phase;
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off && !hold_done) begin
        out_stall <= 1'b1;
        repeat (80) @(posedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end
      phase = $urandom_range(0, 2);
      n = $urandom_range(5, 40);
      repeat (n) begin
        case (phase)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Drive one item and wait for it to be taken.
  task automatic send_op(logic [2:0] mode, logic [31:0] a, logic [31:0] b,
                         logic [31:0] d, logic [5:0] sh, logic [63:0] w);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_operand_a    <= a;
    in_operand_b    <= b;
    in_divisor      <= d;
    in_shift_amount <= sh;
    in_wide_operand <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 70000) - 35000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 4))
      0: return {1'b1, 63'b0};
      1: return {1'b0, {63{1'b1}}};
      2: return {32'b0, $urandom()};
      3: return {$urandom_range(0, 255), $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    int burst;
    logic [2:0] m;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, each mode, zero divisors, negative radicands,
    // the unused modes, and radicands beyond the method's reach
    send_op(MODE_MUL,    32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
    send_op(MODE_MUL,    32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_op(MODE_MUL,    32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_op(MODE_DIV,    32'h0001_0000, 0, 0, 0, 0);
    send_op(MODE_DIV,    32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
    send_op(MODE_DIV,    32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
    send_op(MODE_DIV,    -32'sd7, 32'sd2, 0, 0, 0);
    send_op(MODE_FSQRT,  32'h0004_0000, 0, 0, 0, 0);
    send_op(MODE_FSQRT,  32'h7fff_ffff, 0, 0, 0, 0);
    send_op(MODE_FSQRT,  32'hffff_ffff, 0, 0, 0, 0);
    send_op(MODE_MULDIV, 32'sd1234, 32'sd99, 0, 0, 0);
    send_op(MODE_MULDIV, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 0, 0);
    send_op(MODE_MULDIV, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_op(MODE_MULDIV, -32'sd100, 32'sd7, 32'sd3, 0, 0);
    send_op(MODE_SCALE,  32'h8000_0000, 32'h7fff_ffff, 0, 6'd63, 0);
    send_op(MODE_SCALE,  32'hffff_ffff, 32'h0000_0001, 0, 6'd0, 0);
    send_op(MODE_SCALE,  32'h7fff_ffff, 32'h7fff_ffff, 0, 6'd31, 0);
    send_op(MODE_ISQRT,  0, 0, 0, 0, 64'd0);
    send_op(MODE_ISQRT,  0, 0, 0, 0, {1'b1, 63'b0});
    send_op(MODE_ISQRT,  0, 0, 0, 0, {1'b0, {63{1'b1}}});
    send_op(MODE_ISQRT,  0, 0, 0, 0, 64'h0000_ffff_fffe_0001);
    send_op(3'd6, 32'h1234_5678, 32'h1, 32'h1, 6'd1, 64'd1);
    send_op(3'd7, 32'hffff_ffff, 32'h1, 32'h1, 6'd1, 64'd1);
    in_valid <= 1'b0;

    // random: bursts with random gaps
    for (int i = 0; i < 1400;) begin
      burst = $urandom_range(1, 30);
      if (i >= 300 && !hold_off) begin
        hold_off = 1'b1;  // keep offering while the receiver holds off
        burst = 120;
      end
      if (i >= 700 && i < 730) begin
        // drain completely before carrying on
        in_valid <= 1'b0;
        @(posedge clk iff pending_count == 0);
        i = 730;
      end
      repeat (burst) begin
        m = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
        send_op(m, rnd32(), rnd32(), rnd32(), 6'($urandom_range(0, 63)), rnd64());
        i++;
      end
      in_valid <= 1'b0;
      if ($urandom_range(0, 2) != 0)
        repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b0;

    @(posedge clk iff pending_count == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
